// ===== src/direct_mapped_writeback_name_cache_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped write-back name cache
// Each macro is a clocked implication on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_WRITEBACK_NAME_CACHE_UNIT_MACROS_SVH
`define DIRECT_MAPPED_WRITEBACK_NAME_CACHE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define DMWNC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dmwnc assertion failed");

// Next-cycle implication.
`define DMWNC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dmwnc assertion failed");

`else

`define DMWNC_ASSERT_IMP(label, ante, cons)
`define DMWNC_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== src/dmwnc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwnc_pkg
// Shared types, codes and helpers of the direct-mapped write-back name cache.
// ----------------------------------------------------------------------------
package dmwnc_pkg;

  // Number of cache lines and the width of a line index.
  localparam int unsigned CACHE_LINES = 32;
  localparam int unsigned IDX_W = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;

  // Input commands.
  typedef enum logic [2:0] {
    CMD_RETRIEVE = 3'd0,
    CMD_STORE    = 3'd1,
    CMD_REMOVE   = 3'd2,
    CMD_FILL     = 3'd3,
    CMD_FLUSH    = 3'd4
  } cmd_t;

  // Result kinds.
  typedef enum logic [2:0] {
    K_ACK       = 3'd0,
    K_HIT       = 3'd1,
    K_NOTFOUND  = 3'd2,
    K_FETCH     = 3'd3,
    K_WRITEBACK = 3'd4,
    K_DELETE    = 3'd5,
    K_BUSY      = 3'd6
  } kind_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_WB,
    S_FIN,
    S_FL_SCAN,
    S_FL_WB
  } state_t;

  // One line of the tag/value memory.
  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] value;
  } line_t;

  // Access request from the sequencer to the line memory.
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    line_t            wr_data;
  } line_req_t;

  // Line that a name maps to.
  function automatic logic [IDX_W-1:0] line_index(input logic [31:0] nm);
    line_index = IDX_W'(nm % CACHE_LINES);
  endfunction

endpackage

// ===== src/dmwnc_line_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwnc_line_ram
// Tag and value storage: one write port and one registered read port.
// ----------------------------------------------------------------------------
module dmwnc_line_ram (
  input  logic                 clk,
  input  dmwnc_pkg::line_req_t req,
  output dmwnc_pkg::line_t     rd_data
);
  import dmwnc_pkg::*;

  line_t mem [CACHE_LINES];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== src/dmwnc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmwnc_ctrl
// Sequencer of the name cache: lookup, line update, flush walk and results.
// ----------------------------------------------------------------------------
`include "direct_mapped_writeback_name_cache_unit_macros.svh"

module dmwnc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           command,
  input  logic [31:0]          name,
  input  logic [31:0]          objnum,
  input  logic                 found,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           kind,
  output logic [31:0]          key_name,
  output logic [31:0]          value,
  output logic                 last,
  output dmwnc_pkg::line_req_t ram_req,
  input  dmwnc_pkg::line_t     ram_rd_data
);
  import dmwnc_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_LINES - 1);

  state_t state, state_next;

  // Captured transaction.
  logic [2:0]       cmd_q;
  logic [31:0]      name_q;
  logic [31:0]      obj_q;
  logic             found_q;
  logic [IDX_W-1:0] lidx;
  logic [IDX_W-1:0] fl_idx;

  // Per-line status flags.
  logic [CACHE_LINES-1:0] line_valid;
  logic [CACHE_LINES-1:0] line_dirty;
  logic [CACHE_LINES-1:0] line_on_disk;

  logic [31:0] pending_name;
  logic        fetch_pending;

  // Planned results of the current transaction.
  logic        wb_need_next;
  logic [31:0] wb_tag, wb_value;
  kind_t       fin_kind, fin_kind_next;
  logic [31:0] fin_key, fin_key_next;
  logic [31:0] fin_value, fin_value_next;
  logic        plan_load;

  // Control strobes from the sequencer.
  logic             accept;
  logic             out_free;
  logic             hit;
  logic             victim_dirty;
  logic             emit;
  kind_t            emit_kind;
  logic [31:0]      emit_key;
  logic [31:0]      emit_value;
  logic             emit_last;
  logic             flag_we;
  logic [IDX_W-1:0] flag_idx;
  logic             flag_v, flag_d, flag_o;
  logic             pend_set, pend_clr;
  logic             fl_start, fl_step;

  kind_t       out_kind;
  logic [31:0] out_key, out_value;
  logic        out_last;

  assign in_ready     = (state == S_IDLE);
  assign accept       = in_valid && in_ready;
  assign out_free     = !out_valid || out_ready;
  assign hit          = line_valid[lidx] && (ram_rd_data.tag == name_q);
  assign victim_dirty = line_valid[lidx] && line_dirty[lidx];

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory requests, flag updates and result emission.
  always_comb begin
    state_next        = state;
    ram_req           = '0;
    flag_we           = 1'b0;
    flag_idx          = lidx;
    flag_v            = line_valid[lidx];
    flag_d            = line_dirty[lidx];
    flag_o            = line_on_disk[lidx];
    pend_set          = 1'b0;
    pend_clr          = 1'b0;
    plan_load         = 1'b0;
    wb_need_next      = 1'b0;
    fin_kind_next     = K_ACK;
    fin_key_next      = name_q;
    fin_value_next    = '0;
    fl_start          = 1'b0;
    fl_step           = 1'b0;
    emit              = 1'b0;
    emit_kind         = fin_kind;
    emit_key          = fin_key;
    emit_value        = fin_value;
    emit_last         = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = (command == CMD_FILL) ? line_index(pending_name)
                                                  : line_index(name);
          state_next      = S_LOOK;
        end
      end
      S_LOOK: begin
        plan_load  = 1'b1;
        state_next = S_FIN;
        if (cmd_q == CMD_FILL) begin
          // Fill answers the pending fetch, or acks when none is pending.
          if (fetch_pending) begin
            pend_clr     = 1'b1;
            fin_key_next = pending_name;
            if (!found_q) begin
              fin_kind_next = K_NOTFOUND;
            end else begin
              wb_need_next     = victim_dirty;
              ram_req.wr_en    = 1'b1;
              ram_req.wr_addr  = lidx;
              ram_req.wr_data  = '{tag: pending_name, value: obj_q};
              flag_we          = 1'b1;
              flag_v           = 1'b1;
              flag_d           = 1'b0;
              flag_o           = 1'b1;
              fin_kind_next    = K_HIT;
              fin_value_next   = obj_q;
            end
          end
        end else if (cmd_q > CMD_FLUSH) begin
          // Unknown command: plain ack.
          fin_kind_next = K_ACK;
        end else if (fetch_pending) begin
          fin_kind_next = K_BUSY;
        end else begin
          case (cmd_q)
            CMD_RETRIEVE: begin
              if (hit) begin
                fin_kind_next  = K_HIT;
                fin_value_next = ram_rd_data.value;
              end else begin
                pend_set      = 1'b1;
                fin_kind_next = K_FETCH;
              end
            end
            CMD_STORE: begin
              ram_req.wr_addr = lidx;
              ram_req.wr_data = '{tag: name_q, value: obj_q};
              if (hit) begin
                if (ram_rd_data.value != obj_q) begin
                  ram_req.wr_en = 1'b1;
                  flag_we       = 1'b1;
                  flag_d        = 1'b1;
                end
              end else begin
                wb_need_next  = victim_dirty;
                ram_req.wr_en = 1'b1;
                flag_we       = 1'b1;
                flag_v        = 1'b1;
                flag_d        = 1'b1;
                flag_o        = 1'b0;
              end
              fin_kind_next = K_ACK;
            end
            CMD_REMOVE: begin
              fin_kind_next = K_DELETE;
              if (hit) begin
                flag_we = 1'b1;
                flag_v  = 1'b0;
                if (!line_on_disk[lidx]) begin
                  fin_kind_next = K_ACK;
                end
              end
            end
            default: begin
              // Flush: walk the lines, then ack.
              fl_start      = 1'b1;
              fin_kind_next = K_ACK;
              state_next    = S_FL_SCAN;
            end
          endcase
        end
        if (wb_need_next) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        emit_kind  = K_WRITEBACK;
        emit_key   = wb_tag;
        emit_value = wb_value;
        emit_last  = 1'b0;
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FL_SCAN: begin
        if (line_valid[fl_idx] && line_dirty[fl_idx]) begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = fl_idx;
          state_next      = S_FL_WB;
        end else if (fl_idx == LAST_IDX) begin
          state_next = S_FIN;
        end else begin
          fl_step = 1'b1;
        end
      end
      S_FL_WB: begin
        emit_kind  = K_WRITEBACK;
        emit_key   = ram_rd_data.tag;
        emit_value = ram_rd_data.value;
        emit_last  = 1'b0;
        flag_idx   = fl_idx;
        flag_v     = line_valid[fl_idx];
        flag_d     = 1'b0;
        flag_o     = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          flag_we = 1'b1;
          if (fl_idx == LAST_IDX) begin
            state_next = S_FIN;
          end else begin
            fl_step    = 1'b1;
            state_next = S_FL_SCAN;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Capture of the accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= command;
      name_q  <= name;
      obj_q   <= objnum;
      found_q <= found;
      lidx    <= (command == CMD_FILL) ? line_index(pending_name) : line_index(name);
    end
  end

  // Flush line counter.
  always_ff @(posedge clk) begin
    if (fl_start) begin
      fl_idx <= '0;
    end else if (fl_step) begin
      fl_idx <= fl_idx + IDX_W'(1);
    end
  end

  // Line flags; reset marks every line empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_valid   <= '0;
      line_dirty   <= '0;
      line_on_disk <= '0;
    end else if (flag_we) begin
      line_valid[flag_idx]   <= flag_v;
      line_dirty[flag_idx]   <= flag_d;
      line_on_disk[flag_idx] <= flag_o;
    end
  end

  // Outstanding fetch.
  always_ff @(posedge clk) begin
    if (rst) begin
      fetch_pending <= 1'b0;
      pending_name  <= '0;
    end else if (pend_set) begin
      fetch_pending <= 1'b1;
      pending_name  <= name_q;
    end else if (pend_clr) begin
      fetch_pending <= 1'b0;
    end
  end

  // Result plan, taken while the line read data is at hand.
  always_ff @(posedge clk) begin
    if (plan_load) begin
      wb_tag    <= ram_rd_data.tag;
      wb_value  <= ram_rd_data.value;
      fin_kind  <= fin_kind_next;
      fin_key   <= fin_key_next;
      fin_value <= fin_value_next;
    end
  end

  // Output register; it parts the sequencer from a stalled receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind  <= emit_kind;
      out_key   <= emit_key;
      out_value <= emit_value;
      out_last  <= emit_last;
    end
  end

  assign kind     = out_kind;
  assign key_name = out_key;
  assign value    = out_value;
  assign last     = out_last;

  // A result is loaded only when the output register can take it.
  `DMWNC_ASSERT_IMP(a_emit_room, emit, !out_valid || out_ready)
  // An accepted transaction always goes to the lookup step.
  `DMWNC_ASSERT_NXT(a_accept_look, accept, state == S_LOOK)
  // The flush walk writes back only valid dirty lines.
  `DMWNC_ASSERT_IMP(a_flush_dirty, state == S_FL_WB,
                    line_valid[fl_idx] && line_dirty[fl_idx])
  // A writeback is never the final result of a transaction.
  `DMWNC_ASSERT_IMP(a_wb_not_last, out_valid && out_kind == K_WRITEBACK, !out_last)
  // A planned victim writeback is emitted before the final result.
  `DMWNC_ASSERT_NXT(a_wb_order, state == S_LOOK && wb_need_next, state == S_WB)

endmodule

// ===== src/direct_mapped_writeback_name_cache_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_writeback_name_cache_unit
// Direct-mapped write-back cache of name to object-number bindings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries command, name, objnum and found.
//   Output channel (out_valid/out_ready) carries kind, key_name, value and
//   last; last marks the final result of one input transaction.
//   Fetch, writeback and delete results are requests to the backing store;
//   a fetched value comes back later as a fill command.
//   Retrieve, store, remove and fill pass through a line read, a lookup step,
//   a victim writeback step if needed and a final result step; the block is
//   ready for the next transaction once the final result is loaded. Flush
//   scans every line and adds a line read and a writeback step per dirty line.
//   These steps come from the sequencer and the single read port of the
//   line memory: one line read, then one line update or writeback.
//   Reset empties every line and drops any pending fetch at once.
//   A stalled receiver holds the output register; the sequencer waits for
//   it before loading the next result, and the input stays not ready.
// ----------------------------------------------------------------------------
module direct_mapped_writeback_name_cache_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [31:0] name,
  input  logic [31:0] objnum,
  input  logic        found,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] key_name,
  output logic [31:0] value,
  output logic        last
);
  import dmwnc_pkg::*;

  line_req_t ram_req;
  line_t     ram_rd_data;

  // Sequencer.
  dmwnc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .name       (name),
    .objnum     (objnum),
    .found      (found),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .key_name   (key_name),
    .value      (value),
    .last       (last),
    .ram_req    (ram_req),
    .ram_rd_data(ram_rd_data)
  );

  // Tag and value memory.
  dmwnc_line_ram u_line_ram (
    .clk    (clk),
    .req    (ram_req),
    .rd_data(ram_rd_data)
  );

endmodule
